### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ctp_pkg.sv
// ----------------------------------------------------------------------------
// Circle through three points: package
// Widths, lane codes and the coefficient bundle shared by the pipeline.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int COORD_W   = 16;
    localparam int SQ1_W     = 31;
    localparam int PROD_W    = 32;
    localparam int DIFF_W    = 17;
    localparam int K_W       = 33;
    localparam int PA_W      = 50;
    localparam int PC_W      = 66;
    localparam int DET_W     = 35;
    localparam int NUM_W     = 68;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = NUM_W + FRAC_W;
    localparam int RND_W     = QUO_W + 1;
    localparam int REM_W     = 35;
    localparam int LANES     = 3;
    localparam int COEF_AB_W = 48;
    localparam int COEF_C_W  = 64;
    localparam int HALF_W    = 24;
    localparam int PART_W    = 2 * HALF_W;
    localparam int SQ_W      = 4 * HALF_W;
    localparam int RV_W      = 98;
    localparam int RAD_SHIFT = 18;
    localparam int ROOT_W    = 49;
    localparam int RAD_W     = 48;
    localparam int PRE_N     = 4;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_C = 2;

    localparam int LANE_OUT_W [LANES] = '{COEF_AB_W, COEF_AB_W, COEF_C_W};

    typedef struct packed {
        logic signed [COEF_AB_W-1:0] coef_x;
        logic signed [COEF_AB_W-1:0] coef_y;
        logic signed [COEF_C_W-1:0]  coef_const;
        logic                        overflow;
        logic                        degenerate;
    } ctp_coef_t;

    function automatic logic [COEF_C_W-1:0] lane_limit(input int lane);
        logic [COEF_C_W-1:0] one;
        one = COEF_C_W'(1);
        return (one << (LANE_OUT_W[lane] - 1)) - one;
    endfunction

endpackage

### rtl/core/ctp_front.sv
// ----------------------------------------------------------------------------
// Circle through three points: determinant front end
// Four register stages forming the main determinant and the three numerators.
// ----------------------------------------------------------------------------
module ctp_front
    import ctp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic signed [COORD_W-1:0] third_x,
    input  logic signed [COORD_W-1:0] third_y,
    output logic                     out_valid,
    output logic signed [DET_W-1:0]  det,
    output logic signed [NUM_W-1:0]  num [LANES]
);

    logic [PRE_N-1:0]          vld_reg;
    logic signed [COORD_W-1:0] px [3];
    logic signed [COORD_W-1:0] py [3];

    logic [SQ1_W-1:0]          sqx_reg [3], sqx_next [3];
    logic [SQ1_W-1:0]          sqy_reg [3], sqy_next [3];
    logic signed [PROD_W-1:0]  crs_reg [3][2], crs_next [3][2];
    logic signed [DIFF_W-1:0]  dy_reg [3], dy_next [3];
    logic signed [DIFF_W-1:0]  dx_reg [3], dx_next [3];
    logic signed [K_W-1:0]     k_reg [3], k_next [3];
    logic signed [K_W-1:0]     m_reg [3], m_next [3];
    logic signed [DIFF_W-1:0]  dy2_reg [3], dy2_next [3];
    logic signed [DIFF_W-1:0]  dx2_reg [3], dx2_next [3];
    logic signed [PA_W-1:0]    pa_reg [3], pa_next [3];
    logic signed [PA_W-1:0]    pb_reg [3], pb_next [3];
    logic signed [PC_W-1:0]    pc_reg [3], pc_next [3];
    logic signed [DET_W-1:0]   det3_reg, det3_next;
    logic signed [NUM_W-1:0]   num_reg [LANES], num_next [LANES];
    logic signed [DET_W-1:0]   det_reg, det_next;

    assign px[0] = first_x;
    assign px[1] = second_x;
    assign px[2] = third_x;
    assign py[0] = first_y;
    assign py[1] = second_y;
    assign py[2] = third_y;

    always_comb
    begin : p_next
        int j;
        int k;
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            sqx_next[i]    = SQ1_W'(PROD_W'(px[i]) * PROD_W'(px[i]));
            sqy_next[i]    = SQ1_W'(PROD_W'(py[i]) * PROD_W'(py[i]));
            crs_next[i][0] = PROD_W'(px[j]) * PROD_W'(py[k]);
            crs_next[i][1] = PROD_W'(px[k]) * PROD_W'(py[j]);
            dy_next[i]     = DIFF_W'(py[j]) - DIFF_W'(py[k]);
            dx_next[i]     = DIFF_W'(px[k]) - DIFF_W'(px[j]);

            k_next[i]   = K_W'(0) - K_W'(sqx_reg[i]) - K_W'(sqy_reg[i]);
            m_next[i]   = K_W'(crs_reg[i][0]) - K_W'(crs_reg[i][1]);
            dy2_next[i] = dy_reg[i];
            dx2_next[i] = dx_reg[i];

            pa_next[i] = PA_W'(k_reg[i]) * PA_W'(dy2_reg[i]);
            pb_next[i] = PA_W'(k_reg[i]) * PA_W'(dx2_reg[i]);
            pc_next[i] = PC_W'(k_reg[i]) * PC_W'(m_reg[i]);
        end
        det3_next = DET_W'(m_reg[0]) + DET_W'(m_reg[1]) + DET_W'(m_reg[2]);

        num_next[LANE_X] = NUM_W'(pa_reg[0]) + NUM_W'(pa_reg[1]) + NUM_W'(pa_reg[2]);
        num_next[LANE_Y] = NUM_W'(pb_reg[0]) + NUM_W'(pb_reg[1]) + NUM_W'(pb_reg[2]);
        num_next[LANE_C] = NUM_W'(pc_reg[0]) + NUM_W'(pc_reg[1]) + NUM_W'(pc_reg[2]);
        det_next         = det3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PRE_N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            crs_reg  <= crs_next;
            dy_reg   <= dy_next;
            dx_reg   <= dx_next;
            k_reg    <= k_next;
            m_reg    <= m_next;
            dy2_reg  <= dy2_next;
            dx2_reg  <= dx2_next;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
            det3_reg <= det3_next;
            num_reg  <= num_next;
            det_reg  <= det_next;
        end
    end

    assign out_valid = vld_reg[PRE_N-1];
    assign det       = det_reg;
    assign num       = num_reg;

endmodule

### rtl/core/ctp_div.sv
// ----------------------------------------------------------------------------
// Circle through three points: coefficient divider
// Three lanes of a pipelined restoring divider, one quotient bit per stage,
// followed by rounding and saturation stages.
// ----------------------------------------------------------------------------
module ctp_div
    import ctp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DET_W-1:0] det,
    input  logic signed [NUM_W-1:0] num [LANES],
    output logic                    out_valid,
    output ctp_coef_t               coef
);

    localparam int LAST = QUO_W + 2;

    logic [LAST:0]          vld_reg;
    logic [REM_W-1:0]       den_reg [QUO_W+1], den_next [QUO_W+1];
    logic                   degen_reg [LAST+1], degen_next [LAST+1];
    logic [REM_W-1:0]       rem_reg [QUO_W+1][LANES], rem_next [QUO_W+1][LANES];
    logic [QUO_W-1:0]       dvd_reg [QUO_W+1][LANES], dvd_next [QUO_W+1][LANES];
    logic                   neg_reg [QUO_W+2][LANES], neg_next [QUO_W+2][LANES];
    logic [RND_W-1:0]       rnd_reg [LANES], rnd_next [LANES];
    logic [COEF_C_W-1:0]    res_reg [LANES], res_next [LANES];
    logic                   sat_reg [LANES], sat_next [LANES];

    always_comb
    begin : p_next
        logic [REM_W:0]      trial;
        logic                fit;
        logic [NUM_W-1:0]    mag;
        logic                up;
        logic [RND_W-1:0]    limx;
        logic                sat;
        logic [COEF_C_W-1:0] mag_out;

        den_next[0]   = det[DET_W-1] ? REM_W'(-det) : REM_W'(det);
        degen_next[0] = (det == '0);
        for (int l = 0; l < LANES; l++)
        begin
            mag            = num[l][NUM_W-1] ? NUM_W'(-num[l]) : NUM_W'(num[l]);
            rem_next[0][l] = '0;
            dvd_next[0][l] = {mag, FRAC_W'(0)};
            neg_next[0][l] = num[l][NUM_W-1] ^ det[DET_W-1];
        end

        for (int s = 0; s < QUO_W; s++)
        begin
            den_next[s+1]   = den_reg[s];
            degen_next[s+1] = degen_reg[s];
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_reg[s][l], dvd_reg[s][l][QUO_W-1]};
                fit   = trial >= {1'b0, den_reg[s]};
                rem_next[s+1][l] = fit ? REM_W'(trial - {1'b0, den_reg[s]})
                                       : trial[REM_W-1:0];
                dvd_next[s+1][l] = {dvd_reg[s][l][QUO_W-2:0], fit};
                neg_next[s+1][l] = neg_reg[s][l];
            end
        end

        degen_next[QUO_W+1] = degen_reg[QUO_W];
        for (int l = 0; l < LANES; l++)
        begin
            up = {rem_reg[QUO_W][l], 1'b0} >= {1'b0, den_reg[QUO_W]};
            rnd_next[l] = {1'b0, dvd_reg[QUO_W][l]} + RND_W'(up);
            neg_next[QUO_W+1][l] = neg_reg[QUO_W][l];
        end

        degen_next[LAST] = degen_reg[QUO_W+1];
        for (int l = 0; l < LANES; l++)
        begin
            limx    = RND_W'(lane_limit(l)) + RND_W'(neg_reg[QUO_W+1][l]);
            sat     = rnd_reg[l] > limx;
            mag_out = sat ? limx[COEF_C_W-1:0] : rnd_reg[l][COEF_C_W-1:0];
            res_next[l] = neg_reg[QUO_W+1][l] ? -mag_out : mag_out;
            sat_next[l] = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg   <= den_next;
            degen_reg <= degen_next;
            rem_reg   <= rem_next;
            dvd_reg   <= dvd_next;
            neg_reg   <= neg_next;
            rnd_reg   <= rnd_next;
            res_reg   <= res_next;
            sat_reg   <= sat_next;
        end
    end

    always_comb
    begin
        coef.coef_x     = res_reg[LANE_X][COEF_AB_W-1:0];
        coef.coef_y     = res_reg[LANE_Y][COEF_AB_W-1:0];
        coef.coef_const = res_reg[LANE_C];
        coef.overflow   = sat_reg[LANE_X] | sat_reg[LANE_Y] | sat_reg[LANE_C];
        coef.degenerate = degen_reg[LAST];
    end

    assign out_valid = vld_reg[LAST];

endmodule

### rtl/core/ctp_radius.sv
// ----------------------------------------------------------------------------
// Circle through three points: radius unit
// Forms a*a + b*b - 4c from split products, then takes the integer square
// root one result bit per stage.
// ----------------------------------------------------------------------------
module ctp_radius
    import ctp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  ctp_coef_t        coef,
    output logic             out_valid,
    output ctp_coef_t        coef_out,
    output logic [RAD_W-1:0] radius
);

    localparam int SIDE_N = PRE_N + ROOT_W;

    logic [SIDE_N-1:0]      vld_reg;
    ctp_coef_t              side_reg [SIDE_N], side_next [SIDE_N];
    logic [COEF_AB_W-1:0]   am_reg, am_next;
    logic [COEF_AB_W-1:0]   bm_reg, bm_next;
    logic [PART_W-1:0]      part_reg [6], part_next [6];
    logic [SQ_W-1:0]        asq_reg, asq_next;
    logic [SQ_W-1:0]        bsq_reg, bsq_next;
    logic [RV_W-1:0]        rem_reg [ROOT_W+1], rem_next [ROOT_W+1];
    logic [ROOT_W-1:0]      res_reg [ROOT_W+1], res_next [ROOT_W+1];
    logic                   neg_reg [ROOT_W+1], neg_next [ROOT_W+1];

    always_comb
    begin : p_next
        logic [HALF_W-1:0] ah;
        logic [HALF_W-1:0] al;
        logic [HALF_W-1:0] bh;
        logic [HALF_W-1:0] bl;
        logic [RV_W-1:0]   rv;
        logic [RV_W-1:0]   inc;
        logic              fit;
        int                i;

        side_next[0] = coef;
        am_next = coef.coef_x[COEF_AB_W-1] ? COEF_AB_W'(-coef.coef_x)
                                          : COEF_AB_W'(coef.coef_x);
        bm_next = coef.coef_y[COEF_AB_W-1] ? COEF_AB_W'(-coef.coef_y)
                                          : COEF_AB_W'(coef.coef_y);

        side_next[1] = side_reg[0];
        ah = am_reg[COEF_AB_W-1 -: HALF_W];
        al = am_reg[HALF_W-1:0];
        bh = bm_reg[COEF_AB_W-1 -: HALF_W];
        bl = bm_reg[HALF_W-1:0];
        part_next[0] = PART_W'(ah) * PART_W'(ah);
        part_next[1] = PART_W'(ah) * PART_W'(al);
        part_next[2] = PART_W'(al) * PART_W'(al);
        part_next[3] = PART_W'(bh) * PART_W'(bh);
        part_next[4] = PART_W'(bh) * PART_W'(bl);
        part_next[5] = PART_W'(bl) * PART_W'(bl);

        side_next[2] = side_reg[1];
        asq_next = (SQ_W'(part_reg[0]) << (2 * HALF_W))
                 + (SQ_W'(part_reg[1]) << (HALF_W + 1))
                 + SQ_W'(part_reg[2]);
        bsq_next = (SQ_W'(part_reg[3]) << (2 * HALF_W))
                 + (SQ_W'(part_reg[4]) << (HALF_W + 1))
                 + SQ_W'(part_reg[5]);

        side_next[3] = side_reg[2];
        rv = RV_W'(asq_reg) + RV_W'(bsq_reg)
           - (RV_W'(side_reg[2].coef_const) << RAD_SHIFT);
        rem_next[0] = rv;
        res_next[0] = '0;
        neg_next[0] = rv[RV_W-1];

        for (int k = 0; k < ROOT_W; k++)
        begin
            i   = ROOT_W - 1 - k;
            inc = (RV_W'(res_reg[k]) << (i + 1)) | (RV_W'(1) << (2 * i));
            fit = rem_reg[k] >= inc;
            rem_next[k+1]    = fit ? rem_reg[k] - inc : rem_reg[k];
            res_next[k+1]    = res_reg[k];
            res_next[k+1][i] = fit;
            neg_next[k+1]    = neg_reg[k];
            side_next[PRE_N+k] = side_reg[PRE_N-1+k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SIDE_N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            am_reg   <= am_next;
            bm_reg   <= bm_next;
            part_reg <= part_next;
            asq_reg  <= asq_next;
            bsq_reg  <= bsq_next;
            rem_reg  <= rem_next;
            res_reg  <= res_next;
            neg_reg  <= neg_next;
        end
    end

    assign out_valid = vld_reg[SIDE_N-1];
    assign coef_out  = side_reg[SIDE_N-1];
    assign radius    = neg_reg[ROOT_W] ? '0 : res_reg[ROOT_W][ROOT_W-1:1];

endmodule

### rtl/core/circle_through_three_points.sv
// ----------------------------------------------------------------------------
// Circle through three points
// Finds x*x + y*y + a*x + b*y + c = 0 through three integer points, with the
// radius, in fixed point with 16 fractional bits (signed; the radius unsigned).
// ----------------------------------------------------------------------------
// The block takes one point triple per clock cycle while point_stall is low and
// presents the circles on its outputs in the order of acceptance. Each
// item passes 145 registers: 4 in the determinant front end, 87 in the
// coefficient divider (an input register, 84 single-bit stages, rounding and
// saturation), 53 in the radius unit (magnitude, split products, squares, the
// radicand and 49 square root stages) and the output register. Collinear or
// coincident points give a degenerate result with all other fields zero. A
// stall on the output freezes the pipeline only while a finished circle is
// ready behind the output register; bubbles still move up.
module circle_through_three_points
    import ctp_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         point_valid,
    output logic                         point_stall,
    input  logic signed [COORD_W-1:0]    first_x,
    input  logic signed [COORD_W-1:0]    first_y,
    input  logic signed [COORD_W-1:0]    second_x,
    input  logic signed [COORD_W-1:0]    second_y,
    input  logic signed [COORD_W-1:0]    third_x,
    input  logic signed [COORD_W-1:0]    third_y,
    output logic                         circle_valid,
    input  logic                         circle_stall,
    output logic signed [COEF_AB_W-1:0]  coef_x,
    output logic signed [COEF_AB_W-1:0]  coef_y,
    output logic signed [COEF_C_W-1:0]   coef_const,
    output logic [RAD_W-1:0]             circle_radius,
    output logic                         degenerate,
    output logic                         overflow
);

    logic                    en;
    logic                    out_free;
    logic                    front_valid;
    logic signed [DET_W-1:0] front_det;
    logic signed [NUM_W-1:0] front_num [LANES];
    logic                    div_valid;
    ctp_coef_t               div_coef;
    logic                    rad_valid;
    ctp_coef_t               rad_coef;
    logic [RAD_W-1:0]        rad_radius;

    logic                        circle_valid_reg;
    logic signed [COEF_AB_W-1:0] coef_x_reg;
    logic signed [COEF_AB_W-1:0] coef_y_reg;
    logic signed [COEF_C_W-1:0]  coef_const_reg;
    logic [RAD_W-1:0]            radius_reg;
    logic                        degenerate_reg;
    logic                        overflow_reg;

    assign out_free    = !circle_valid_reg || !circle_stall;
    assign en          = out_free || !rad_valid;
    assign point_stall = !en;

    ctp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (point_valid),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .third_x   (third_x),
        .third_y   (third_y),
        .out_valid (front_valid),
        .det       (front_det),
        .num       (front_num)
    );

    ctp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .det       (front_det),
        .num       (front_num),
        .out_valid (div_valid),
        .coef      (div_coef)
    );

    ctp_radius u_radius (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .coef      (div_coef),
        .out_valid (rad_valid),
        .coef_out  (rad_coef),
        .radius    (rad_radius)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            circle_valid_reg <= rad_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && rad_valid)
        begin
            if (rad_coef.degenerate)
            begin
                coef_x_reg     <= '0;
                coef_y_reg     <= '0;
                coef_const_reg <= '0;
                radius_reg     <= '0;
                degenerate_reg <= 1'b1;
                overflow_reg   <= 1'b0;
            end
            else
            begin
                coef_x_reg     <= rad_coef.coef_x;
                coef_y_reg     <= rad_coef.coef_y;
                coef_const_reg <= rad_coef.coef_const;
                radius_reg     <= rad_radius;
                degenerate_reg <= 1'b0;
                overflow_reg   <= rad_coef.overflow;
            end
        end
    end

    assign circle_valid  = circle_valid_reg;
    assign coef_x        = coef_x_reg;
    assign coef_y        = coef_y_reg;
    assign coef_const    = coef_const_reg;
    assign circle_radius = radius_reg;
    assign degenerate    = degenerate_reg;
    assign overflow      = overflow_reg;

endmodule

### rtl/core/ctp_checker.sv
// ----------------------------------------------------------------------------
// Circle through three points: port checker
// Watches the ports of the top level for back-pressure and result rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctp_checker
    import ctp_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        point_stall,
    input logic                        circle_valid,
    input logic                        circle_stall,
    input logic signed [COEF_AB_W-1:0] coef_x,
    input logic signed [COEF_AB_W-1:0] coef_y,
    input logic signed [COEF_C_W-1:0]  coef_const,
    input logic [RAD_W-1:0]            circle_radius,
    input logic                        degenerate,
    input logic                        overflow
);

    // A degenerate triple carries nothing but its flag.
    `CTP_ASSERT_SAME(a_degenerate_zero, circle_valid && degenerate, coef_x == '0 && coef_y == '0 && coef_const == '0 && circle_radius == '0 && !overflow, "degenerate result has non-zero fields")

    // The input is only held off while a finished circle is waiting.
    `CTP_ASSERT_SAME(a_stall_cause, point_stall, circle_valid && circle_stall, "input stalled without output back-pressure")

    `CTP_ASSERT_NEXT(a_out_hold, circle_valid && circle_stall, circle_valid && $stable(coef_x) && $stable(coef_const) && $stable(circle_radius), "stalled result changed")

endmodule

bind circle_through_three_points ctp_checker u_ctp_checker (.*);

### dv/tb_circle_through_three_points.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle through three points: testbench
// Drives point triples with random gaps, predicts each circle with exact wide
// integer arithmetic and checks every returned field in order.
// ----------------------------------------------------------------------------

class circle_scoreboard;

    typedef struct {
        logic signed [47:0] cx;
        logic signed [47:0] cy;
        logic signed [63:0] cc;
        logic [47:0]        rad;
        logic               degen;
        logic               ovf;
    } circle_t;

    circle_t pending[$];
    int      errors;

    static function logic signed [63:0] round_div(logic signed [159:0] num,
                                                  logic signed [159:0] den,
                                                  int width, ref bit sat);
        logic [159:0]        n;
        logic [159:0]        d;
        logic [159:0]        q;
        logic [159:0]        r;
        logic [159:0]        lim;
        bit                  neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        n = n << 16;
        q = n / d;
        r = n % d;
        if (2 * r >= d)
        begin
            q = q + 1;
        end
        lim = (160'(1) << (width - 1)) - 1;
        if (neg)
        begin
            lim = lim + 1;
        end
        if (q > lim)
        begin
            sat = 1;
            q = lim;
        end
        return neg ? -64'(q) : 64'(q);
    endfunction

    function void note_points(logic signed [15:0] p[6]);
        logic signed [159:0] x1, y1, x2, y2, x3, y3, k1, k2, k3, m1, m2, m3;
        logic signed [159:0] det, da, db, dc, ea, eb, ec, rv;
        logic [159:0]        root;
        circle_t             e;
        bit                  sat;
        x1 = p[0]; y1 = p[1]; x2 = p[2]; y2 = p[3]; x3 = p[4]; y3 = p[5];
        k1 = -(x1 * x1 + y1 * y1);
        k2 = -(x2 * x2 + y2 * y2);
        k3 = -(x3 * x3 + y3 * y3);
        m1 = x2 * y3 - x3 * y2;
        m2 = x3 * y1 - x1 * y3;
        m3 = x1 * y2 - x2 * y1;
        det = m1 + m2 + m3;
        e = '{default: '0};
        sat = 0;
        if (det == 0)
        begin
            e.degen = 1;
        end
        else
        begin
            da = k1 * (y2 - y3) + k2 * (y3 - y1) + k3 * (y1 - y2);
            db = k1 * (x3 - x2) + k2 * (x1 - x3) + k3 * (x2 - x1);
            dc = k1 * m1 + k2 * m2 + k3 * m3;
            e.cx = round_div(da, det, 48, sat);
            e.cy = round_div(db, det, 48, sat);
            e.cc = round_div(dc, det, 64, sat);
            ea = e.cx;
            eb = e.cy;
            ec = e.cc;
            rv = ea * ea + eb * eb - ec * 160'sd262144;
            if (rv >= 0)
            begin
                root = 0;
                for (int i = 48; i >= 0; i--)
                begin
                    if ((root | (160'(1) << i)) * (root | (160'(1) << i)) <= rv)
                    begin
                        root = root | (160'(1) << i);
                    end
                end
                e.rad = 48'(root >> 1);
            end
            e.ovf = sat;
        end
        pending.push_back(e);
    endfunction

    function void check_circle(circle_t got);
        circle_t e;
        if (pending.size() == 0)
        begin
            report_mismatch("circle with no transaction outstanding");
            return;
        end
        e = pending.pop_front();
        if (got.cx !== e.cx) report_mismatch($sformatf("coef_x %0d exp %0d", got.cx, e.cx));
        if (got.cy !== e.cy) report_mismatch($sformatf("coef_y %0d exp %0d", got.cy, e.cy));
        if (got.cc !== e.cc)
            report_mismatch($sformatf("coef_const %0d exp %0d", got.cc, e.cc));
        if (got.rad !== e.rad)
            report_mismatch($sformatf("radius %0d exp %0d", got.rad, e.rad));
        if (got.degen !== e.degen) report_mismatch("degenerate flag");
        if (got.ovf !== e.ovf) report_mismatch("overflow flag");
    endfunction

    function void report_mismatch(string what);
        errors++;
        if (errors <= 50)
        begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
    endfunction

endclass

module tb_circle_through_three_points;
    import ctp_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        point_valid;
    logic                        point_stall;
    logic signed [COORD_W-1:0]   first_x, first_y, second_x, second_y, third_x, third_y;
    logic                        circle_valid;
    logic                        circle_stall;
    logic signed [COEF_AB_W-1:0] coef_x, coef_y;
    logic signed [COEF_C_W-1:0]  coef_const;
    logic [RAD_W-1:0]            circle_radius;
    logic                        degenerate, overflow;

    circle_scoreboard board;
    int  cycles = 0;
    bit  hold_off;
    bit  sending_done;

    circle_through_three_points dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 40)) - 20);
            2: return $urandom_range(0, 1) ? 16'(32767 - int'($urandom_range(0, 3)))
                                           : 16'(-32768 + int'($urandom_range(0, 3)));
            default: return 16'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic send_points(logic signed [15:0] p[6]);
        first_x <= p[0]; first_y <= p[1]; second_x <= p[2];
        second_y <= p[3]; third_x <= p[4]; third_y <= p[5];
        point_valid <= 1'b1;
        @(posedge clk);
        while (point_stall)
        begin
            @(posedge clk);
        end
        board.note_points(p);
    endtask

    task automatic pause_sender();
        int n;
        n = gap_length();
        if (n > 0)
        begin
            point_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        logic signed [15:0] p[6];
        int mode;
        board = new();
        rst_n = 1'b0;
        point_valid = 1'b0;
        circle_stall = 1'b0;
        hold_off = 1'b0;
        sending_done = 1'b0;
        {first_x, first_y, second_x, second_y, third_x, third_y} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        p = '{0, 0, 1, 0, 0, 1};                     send_points(p);
        p = '{0, 0, 0, 0, 0, 0};                     send_points(p);
        p = '{1, 1, 2, 2, 3, 3};                     send_points(p);
        p = '{-32768, -32768, 32767, -32768, -32768, 32767}; send_points(p);
        p = '{32767, 32767, -32768, 32767, 32767, -32768};   send_points(p);
        p = '{0, 0, 1, 0, 32767, 1};                 send_points(p);
        p = '{-32768, 0, 32767, 1, 32767, 0};        send_points(p);
        p = '{0, -32768, 1, 32767, 0, 32767};        send_points(p);
        p = '{5, 7, 5, 7, 9, 2};                     send_points(p);
        p = '{-1, -1, 1, -1, 0, 1};                  send_points(p);
        p = '{10, 0, -10, 0, 0, 10};                 send_points(p);
        p = '{-32768, -32768, -32767, -32767, 32767, 32766}; send_points(p);
        for (int i = 0; i < 1600; i++)
        begin
            if (i == 400)
            begin
                hold_off <= 1'b1;
            end
            mode = $urandom_range(0, 3);
            foreach (p[j])
            begin
                p[j] = rand_coord(mode);
            end
            if ($urandom_range(0, 19) == 0)
            begin
                p[4] = 16'(p[0] + 2 * (p[2] - p[0]));
                p[5] = 16'(p[1] + 2 * (p[3] - p[1]));
            end
            if (i % 300 > 250)
            begin
                point_valid <= 1'b1;
            end
            else
            begin
                pause_sender();
            end
            send_points(p);
        end
        point_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off && !held)
            begin
                held = 1'b1;
                circle_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            n = ($urandom_range(0, 9) < 7) ? 0 : gap_length();
            circle_stall <= (n > 0);
            repeat (n > 0 ? n : 1) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && circle_valid && !circle_stall)
        begin
            board.check_circle('{coef_x, coef_y, coef_const, circle_radius,
                                 degenerate, overflow});
        end
    end

    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0 && cycles < 400000)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("circle_through_three_points verification clean");
        end
        else
        begin
            $display("circle_through_three_points verification failed");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == 400000)
        begin
            $display("circle_through_three_points verification failed");
            $finish;
        end
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ctp_pkg.sv
rtl/core/ctp_front.sv
rtl/core/ctp_div.sv
rtl/core/ctp_radius.sv
rtl/core/circle_through_three_points.sv
rtl/core/ctp_checker.sv
dv/tb_circle_through_three_points.sv
